@@ hdl/yuv_gamma_balance_corrector_assert.svh @@
// Assertion macros shared by the corrector's RTL files.
// Depends on nothing; included by the modules that check their own logic.
`ifndef YUV_GAMMA_BALANCE_CORRECTOR_ASSERT_SVH
`define YUV_GAMMA_BALANCE_CORRECTOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define YGB_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ygb assertion failed");

// Next-cycle implication, disabled during reset.
`define YGB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ygb assertion failed");

`endif

@@ hdl/ygb_pkg.sv @@
// Shared types and constants of the YUV gamma and balance corrector.
// Depends on nothing; imported by every module of the block.
`default_nettype none

package ygb_pkg;

  // Widest supported sample depth.
  localparam int PixelWidth = 16;

  // Full scale of an RGB channel, 255.0 in unsigned Q8.10.
  localparam logic [17:0] FullScale = 18'd261120;

  // Register indexes of the configuration port.
  localparam logic [2:0] RegBitDepth  = 3'd0;
  localparam logic [2:0] RegModeBits  = 3'd1;
  localparam logic [2:0] RegGammaR    = 3'd2;
  localparam logic [2:0] RegGammaG    = 3'd3;
  localparam logic [2:0] RegGammaB    = 3'd4;
  localparam logic [2:0] RegShadow    = 3'd5;
  localparam logic [2:0] RegMidtone   = 3'd6;
  localparam logic [2:0] RegHighlight = 3'd7;

  // One pixel word in.
  typedef struct packed {
    logic [15:0] luma_in;
    logic [15:0] blue_diff_in;
    logic [15:0] red_diff_in;
    logic        chroma_site;
  } pix_in_t;

  // One pixel word out.
  typedef struct packed {
    logic [15:0] luma_out;
    logic [15:0] blue_diff_out;
    logic [15:0] red_diff_out;
    logic        chroma_valid;
  } pix_out_t;

  // Control that travels with a word through the pipeline.
  typedef struct packed {
    logic valid;
    logic site;
  } ctl_t;

  // RGB triple in Q8.10, channel 0 red, 1 green, 2 blue.
  typedef logic [2:0][17:0] rgb_t;

endpackage

`default_nettype wire

@@ hdl/yuv_gamma_balance_corrector.sv @@
// Top level of the YUV gamma and color balance corrector: configuration
// registers and the pipeline. Depends on ygb_pkg and all ygb_* modules.
`default_nettype none

// The corrector takes one pixel word in every clock cycle: busy is always
// low, so a word is accepted whenever start is high. Each result appears
// on pix_o for exactly one cycle with done_o high, in order; the
// receiver cannot stall it. In order, a word passes the YUV to RGB stage,
// the gamma lanes (one squaring multiply per log2 bit and one root multiply
// per exponent fraction bit, 16 each), the color balance and the
// conversion back. Configuration is written through cfg_we_i, cfg_idx_i and
// cfg_data_i in one cycle and must only change while no word is in flight.
module yuv_gamma_balance_corrector (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  ygb_pkg::pix_in_t  pix_i,
  output logic              done_o,
  output ygb_pkg::pix_out_t pix_o,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_idx_i,
  input  logic [47:0]       cfg_data_i
);
  import ygb_pkg::*;

  logic [4:0]        bit_depth_q;
  logic [3:0]        mode_q;
  logic [2:0][15:0]  gamma_q;
  logic [47:0]       shadow_q, midtone_q, highlight_q;
  logic [4:0]        depth;
  ctl_t              in_ctl, front_ctl, gamma_ctl, bal_ctl;
  rgb_t              front_rgb, gamma_rgb, bal_rgb;

  // Configuration register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_depth_q <= 5'd8;
      mode_q      <= '0;
      gamma_q     <= {3{16'd4096}};
      shadow_q    <= '0;
      midtone_q   <= '0;
      highlight_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegBitDepth:  bit_depth_q <= cfg_data_i[4:0];
        RegModeBits:  mode_q      <= cfg_data_i[3:0];
        RegGammaR:    gamma_q[0]  <= cfg_data_i[15:0];
        RegGammaG:    gamma_q[1]  <= cfg_data_i[15:0];
        RegGammaB:    gamma_q[2]  <= cfg_data_i[15:0];
        RegShadow:    shadow_q    <= cfg_data_i;
        RegMidtone:   midtone_q   <= cfg_data_i;
        RegHighlight: highlight_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Depth limited to the supported range.
  always_comb begin
    if (bit_depth_q < 5'd8) begin
      depth = 5'd8;
    end else if (bit_depth_q > 5'(PixelWidth)) begin
      depth = 5'(PixelWidth);
    end else begin
      depth = bit_depth_q;
    end
  end

  assign busy         = 1'b0;
  assign in_ctl.valid = start && !busy;
  assign in_ctl.site  = pix_i.chroma_site;

  ygb_rgb_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (in_ctl),
    .pix_i   (pix_i),
    .depth_i (depth),
    .ctl_o   (front_ctl),
    .rgb_o   (front_rgb)
  );

  ygb_gamma_lane u_gamma_r (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (front_ctl),
    .t_i      (front_rgb[0]),
    .enable_i (mode_q[0]),
    .gamma_i  (gamma_q[0]),
    .ctl_o    (gamma_ctl),
    .y_o      (gamma_rgb[0])
  );

  ygb_gamma_lane u_gamma_g (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (front_ctl),
    .t_i      (front_rgb[1]),
    .enable_i (mode_q[1]),
    .gamma_i  (gamma_q[1]),
    .ctl_o    (),
    .y_o      (gamma_rgb[1])
  );

  ygb_gamma_lane u_gamma_b (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (front_ctl),
    .t_i      (front_rgb[2]),
    .enable_i (mode_q[2]),
    .gamma_i  (gamma_q[2]),
    .ctl_o    (),
    .y_o      (gamma_rgb[2])
  );

  ygb_balance u_balance (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (gamma_ctl),
    .rgb_i       (gamma_rgb),
    .enable_i    (mode_q[3]),
    .shadow_i    (shadow_q),
    .midtone_i   (midtone_q),
    .highlight_i (highlight_q),
    .ctl_o       (bal_ctl),
    .rgb_o       (bal_rgb)
  );

  ygb_rgb_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (bal_ctl),
    .rgb_i   (bal_rgb),
    .depth_i (depth),
    .done_o  (done_o),
    .pix_o   (pix_o)
  );

endmodule

`default_nettype wire

@@ hdl/ygb_rgb_front.sv @@
// Studio-range YUV to RGB conversion with clipping, three register stages.
// Depends on ygb_pkg and the assertion macro header.
`default_nettype none
`include "yuv_gamma_balance_corrector_assert.svh"

module ygb_rgb_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ygb_pkg::ctl_t    ctl_i,
  input  ygb_pkg::pix_in_t pix_i,
  input  logic [4:0]       depth_i,
  output ygb_pkg::ctl_t    ctl_o,
  output ygb_pkg::rgb_t    rgb_o
);
  import ygb_pkg::*;

  localparam int KY2Rgb = 4768;
  localparam int KV2R   = 6537;
  localparam int KU2G   = 1606;
  localparam int KV2G   = 3330;
  localparam int KU2B   = 8262;

  function automatic logic [17:0] clip_q22(input logic signed [41:0] x);
    logic signed [41:0] y;
    y = (x + 42'sd2048) >>> 12;
    if (x <= 0) return '0;
    if (y > 42'(FullScale)) return FullScale;
    return y[17:0];
  endfunction

  logic [3:0]         shift;
  logic [25:0]        y_sh, u_sh, v_sh;
  logic signed [26:0] c_d, p_d, q_d, c_q, p_q, q_q;
  logic signed [40:0] yc_d, vr_d, ug_d, vg_d, ub_d;
  logic signed [40:0] yc_q, vr_q, ug_q, vg_q, ub_q;
  rgb_t               rgb_d, rgb_q;
  ctl_t               s1_ctl_q, s2_ctl_q, s3_ctl_q;

  // Stage 1: bring samples to 8-bit units in Q.10 and remove the offsets.
  always_comb begin
    shift = 4'(5'd18 - depth_i);
    y_sh  = 26'(pix_i.luma_in) << shift;
    u_sh  = 26'(pix_i.blue_diff_in) << shift;
    v_sh  = 26'(pix_i.red_diff_in) << shift;
    c_d   = $signed({1'b0, y_sh}) - 27'sd16384;
    p_d   = $signed({1'b0, u_sh}) - 27'sd131072;
    q_d   = $signed({1'b0, v_sh}) - 27'sd131072;
  end

  // Stage 2: the five coefficient products.
  always_comb begin
    yc_d = 41'(c_q) * 41'(KY2Rgb);
    vr_d = 41'(q_q) * 41'(KV2R);
    ug_d = 41'(p_q) * 41'(KU2G);
    vg_d = 41'(q_q) * 41'(KV2G);
    ub_d = 41'(p_q) * 41'(KU2B);
  end

  // Stage 3: sums, rounding and clipping to full scale.
  always_comb begin
    rgb_d[0] = clip_q22(42'(yc_q) + 42'(vr_q));
    rgb_d[1] = clip_q22(42'(yc_q) - 42'(ug_q) - 42'(vg_q));
    rgb_d[2] = clip_q22(42'(yc_q) + 42'(ub_q));
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_ctl_q <= '0;
      s2_ctl_q <= '0;
      s3_ctl_q <= '0;
    end else begin
      s1_ctl_q <= ctl_i;
      s2_ctl_q <= s1_ctl_q;
      s3_ctl_q <= s2_ctl_q;
    end
  end

  // Data registers.
  always_ff @(posedge clk_i) begin
    c_q   <= c_d;
    p_q   <= p_d;
    q_q   <= q_d;
    yc_q  <= yc_d;
    vr_q  <= vr_d;
    ug_q  <= ug_d;
    vg_q  <= vg_d;
    ub_q  <= ub_d;
    rgb_q <= rgb_d;
  end

  assign ctl_o = s3_ctl_q;
  assign rgb_o = rgb_q;

  `YGB_ASSERT_NEXT(a_front_enter, clk_i, rst_ni, ctl_i.valid, s1_ctl_q.valid)
  `YGB_ASSERT_IMPLY(a_front_clip, clk_i, rst_ni, ctl_o.valid, (rgb_o[0] <= FullScale) && (rgb_o[1] <= FullScale) && (rgb_o[2] <= FullScale))

endmodule

`default_nettype wire

@@ hdl/ygb_gamma_lane.sv @@
// One channel of the gamma curve: log2 by repeated squaring, scale by the
// exponent, exp2 by root multiplies. Depends on ygb_pkg and the assertion header.
`default_nettype none
`include "yuv_gamma_balance_corrector_assert.svh"

module ygb_gamma_lane (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ygb_pkg::ctl_t ctl_i,
  input  logic [17:0]   t_i,
  input  logic          enable_i,
  input  logic [15:0]   gamma_i,
  output ygb_pkg::ctl_t ctl_o,
  output logic [17:0]   y_o
);
  import ygb_pkg::*;

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] rem, res, bitv;
    rem  = v;
    res  = '0;
    bitv = 64'd1 << 62;
    for (int j = 0; j < 32; j++) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // 2^(-2^-i) in Q.30.
  function automatic logic [29:0] root_q30(input int i);
    logic [63:0] r;
    r = isqrt64(64'd1 << 59);
    for (int j = 2; j <= i; j++) r = isqrt64(r << 30);
    return r[29:0];
  endfunction

  function automatic logic [20:0] log2_q16(input logic [63:0] t);
    int          k;
    logic [63:0] m;
    logic [20:0] res;
    k = 0;
    for (int j = 0; j < 63; j++) if ((t >> (j + 1)) != 0) k = j + 1;
    if (k > 30) k = 30;
    m   = t << (30 - k);
    res = 21'(k) << 16;
    for (int i = 15; i >= 0; i--) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        m      = m >> 1;
        res[i] = 1'b1;
      end
    end
    return res;
  endfunction

  localparam int          Steps   = 16;
  localparam int          ExpIdx  = Steps + 1;
  localparam int          ProdIdx = 2 * Steps + 2;
  localparam int          OutIdx  = 2 * Steps + 3;
  localparam int          Stages  = 2 * Steps + 4;
  localparam logic [20:0] LgFs    = log2_q16(64'(FullScale));

  typedef struct packed {
    logic        zero;
    logic [17:0] t;
    logic [4:0]  k;
    logic [30:0] m;
    logic [15:0] acc;
    logic [8:0]  n;
    logic [47:0] p;
  } lane_t;

  lane_t       dat_d [Stages];
  lane_t       dat_q [Stages];
  ctl_t        ctl_d [Stages];
  ctl_t        ctl_q [Stages];
  logic [4:0]  norm_k;
  logic [20:0] lg_diff;
  logic [36:0] e_prod;
  logic [24:0] e_val;
  logic [5:0]  out_sh;
  logic [48:0] out_rnd, out_v;
  logic [17:0] out_res;

  // Normalize: top set bit and mantissa in [1,2) as Q.30.
  always_comb begin
    norm_k = '0;
    for (int j = 0; j < 18; j++) if (t_i[j]) norm_k = 5'(j);
    dat_d[0]      = '0;
    dat_d[0].zero = (t_i == '0);
    dat_d[0].t    = t_i;
    dat_d[0].k    = norm_k;
    dat_d[0].m    = 31'({13'b0, t_i} << (5'd30 - norm_k));
    ctl_d[0]      = ctl_i;
  end

  // One fraction bit of the logarithm per stage.
  for (genvar i = 1; i <= Steps; i++) begin : g_log
    logic [61:0] sq;
    always_comb begin
      sq       = 62'(dat_q[i-1].m) * 62'(dat_q[i-1].m);
      dat_d[i] = dat_q[i-1];
      ctl_d[i] = ctl_q[i-1];
      if (sq[61]) begin
        dat_d[i].m   = sq[61:31];
        dat_d[i].acc = {dat_q[i-1].acc[14:0], 1'b1};
      end else begin
        dat_d[i].m   = sq[60:30];
        dat_d[i].acc = {dat_q[i-1].acc[14:0], 1'b0};
      end
    end
  end

  // Exponent: distance to full scale in log2 units, times the gamma.
  always_comb begin
    lg_diff            = LgFs - {dat_q[Steps].k, dat_q[Steps].acc};
    e_prod             = 37'(lg_diff) * 37'(gamma_i);
    e_val              = 25'((e_prod + 37'd2048) >> 12);
    dat_d[ExpIdx]      = dat_q[Steps];
    dat_d[ExpIdx].n    = e_val[24:16];
    dat_d[ExpIdx].acc  = e_val[15:0];
    dat_d[ExpIdx].m    = 31'd1073741824;
    ctl_d[ExpIdx]      = ctl_q[Steps];
  end

  // One root multiply per fraction bit of the exponent.
  for (genvar i = 1; i <= Steps; i++) begin : g_exp
    localparam logic [29:0] Root = root_q30(i);
    logic [60:0] prod;
    always_comb begin
      prod              = 61'(dat_q[ExpIdx+i-1].m) * 61'(Root);
      dat_d[ExpIdx+i]   = dat_q[ExpIdx+i-1];
      ctl_d[ExpIdx+i]   = ctl_q[ExpIdx+i-1];
      if (dat_q[ExpIdx+i-1].acc[Steps-i]) dat_d[ExpIdx+i].m = prod[60:30];
    end
  end

  // Scale the fraction by full scale.
  always_comb begin
    dat_d[ProdIdx]   = dat_q[ProdIdx-1];
    dat_d[ProdIdx].p = 48'(FullScale) * 48'(dat_q[ProdIdx-1].m);
    ctl_d[ProdIdx]   = ctl_q[ProdIdx-1];
  end

  // Integer part as a rounded right shift, then limit and bypass.
  always_comb begin
    out_sh  = 6'd30 + 6'(dat_q[ProdIdx].n[4:0]);
    out_rnd = 49'(dat_q[ProdIdx].p) + (49'd1 << (out_sh - 6'd1));
    out_v   = out_rnd >> out_sh;
    out_res = (out_v > 49'(FullScale)) ? FullScale : out_v[17:0];
    if (dat_q[ProdIdx].zero || (dat_q[ProdIdx].n >= 9'd19)) out_res = '0;
    dat_d[OutIdx]   = dat_q[ProdIdx];
    dat_d[OutIdx].t = enable_i ? out_res : dat_q[ProdIdx].t;
    ctl_d[OutIdx]   = ctl_q[ProdIdx];
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < Stages; s++) ctl_q[s] <= '0;
    end else begin
      for (int s = 0; s < Stages; s++) ctl_q[s] <= ctl_d[s];
    end
  end

  // Data registers.
  always_ff @(posedge clk_i) begin
    for (int s = 0; s < Stages; s++) dat_q[s] <= dat_d[s];
  end

  assign ctl_o = ctl_q[OutIdx];
  assign y_o   = dat_q[OutIdx].t;

  `YGB_ASSERT_IMPLY(a_gamma_range, clk_i, rst_ni, ctl_o.valid, y_o <= FullScale)

endmodule

`default_nettype wire

@@ hdl/ygb_balance.sv @@
// Shadow, midtone and highlight color balance weighted by luma, six stages.
// Depends on ygb_pkg.
`default_nettype none

module ygb_balance (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ygb_pkg::ctl_t ctl_i,
  input  ygb_pkg::rgb_t rgb_i,
  input  logic          enable_i,
  input  logic [47:0]   shadow_i,
  input  logic [47:0]   midtone_i,
  input  logic [47:0]   highlight_i,
  output ygb_pkg::ctl_t ctl_o,
  output ygb_pkg::rgb_t rgb_o
);
  import ygb_pkg::*;

  localparam int          Stages  = 6;
  localparam int          Delay   = 5;
  localparam logic [14:0] Unity   = 15'd16384;
  // ceil(2^31 / 255), exact for the quotient range used here.
  localparam logic [47:0] Recip   = 48'd8421505;

  ctl_t               ctl_q [Stages];
  rgb_t               rgb_q [Delay];
  logic [28:0]        lr_d, lr_q;
  logic [29:0]        lg_d, lg_q;
  logic [27:0]        lb_d, lb_q;
  logic [23:0]        y_d, y_q;
  logic [47:0]        yq_d, yq_q;
  logic [16:0]        tl;
  logic [14:0]        sw_d, mw_d, hw_d, sw_q, mw_q, hw_q;
  logic signed [31:0] ws_d [3];
  logic signed [31:0] wm_d [3];
  logic signed [31:0] wh_d [3];
  logic signed [31:0] ws_q [3];
  logic signed [31:0] wm_q [3];
  logic signed [31:0] wh_q [3];
  logic signed [33:0] bx   [3];
  logic signed [33:0] bxr  [3];
  rgb_t               res_d, res_q;

  // Luma products.
  always_comb begin
    lr_d = 29'(rgb_i[0]) * 29'd1225;
    lg_d = 30'(rgb_i[1]) * 30'd2404;
    lb_d = 28'(rgb_i[2]) * 28'd467;
  end

  // Luma sum with rounding offset; the factor 128 of the divisor is a shift.
  assign y_d  = 24'((31'(lr_q) + 31'(lg_q) + 31'(lb_q) + 31'd16320) >> 7);
  // Division by 255 as a reciprocal multiply.
  assign yq_d = 48'(y_q) * Recip;

  // Shadow, midtone and highlight weights from twice the luma in Q.14.
  always_comb begin
    tl   = yq_q[47:31];
    sw_d = (tl >= 17'(Unity)) ? '0 : 15'(17'(Unity) - tl);
    if (tl <= 17'(Unity)) begin
      hw_d = '0;
    end else if (tl - 17'(Unity) > 17'(Unity)) begin
      hw_d = Unity;
    end else begin
      hw_d = 15'(tl - 17'(Unity));
    end
    mw_d = Unity - sw_d - hw_d;
  end

  // Weight times gain, nine products.
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      ws_d[ch] = 32'($signed({1'b0, sw_q})) * 32'($signed(shadow_i[16*ch +: 16]));
      wm_d[ch] = 32'($signed({1'b0, mw_q})) * 32'($signed(midtone_i[16*ch +: 16]));
      wh_d[ch] = 32'($signed({1'b0, hw_q})) * 32'($signed(highlight_i[16*ch +: 16]));
    end
  end

  // Sum, round, clip, or pass the channel untouched when balance is off.
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      bx[ch]  = $signed({5'b0, rgb_q[Delay-1][ch], 11'b0}) + 34'(ws_q[ch]) + 34'(wm_q[ch])
                + 34'(wh_q[ch]);
      bxr[ch] = (bx[ch] + 34'sd1024) >>> 11;
      if (!enable_i) begin
        res_d[ch] = rgb_q[Delay-1][ch];
      end else if (bx[ch] <= 0) begin
        res_d[ch] = '0;
      end else if (bxr[ch] > 34'(FullScale)) begin
        res_d[ch] = FullScale;
      end else begin
        res_d[ch] = bxr[ch][17:0];
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < Stages; s++) ctl_q[s] <= '0;
    end else begin
      ctl_q[0] <= ctl_i;
      for (int s = 1; s < Stages; s++) ctl_q[s] <= ctl_q[s-1];
    end
  end

  // Data registers.
  always_ff @(posedge clk_i) begin
    rgb_q[0] <= rgb_i;
    for (int s = 1; s < Delay; s++) rgb_q[s] <= rgb_q[s-1];
    lr_q  <= lr_d;
    lg_q  <= lg_d;
    lb_q  <= lb_d;
    y_q   <= y_d;
    yq_q  <= yq_d;
    sw_q  <= sw_d;
    mw_q  <= mw_d;
    hw_q  <= hw_d;
    for (int ch = 0; ch < 3; ch++) begin
      ws_q[ch] <= ws_d[ch];
      wm_q[ch] <= wm_d[ch];
      wh_q[ch] <= wh_d[ch];
    end
    res_q <= res_d;
  end

  assign ctl_o = ctl_q[Stages-1];
  assign rgb_o = res_q;

endmodule

`default_nettype wire

@@ hdl/ygb_rgb_back.sv @@
// RGB back to studio-range YUV at the configured depth, three stages.
// Depends on ygb_pkg and the assertion macro header.
`default_nettype none
`include "yuv_gamma_balance_corrector_assert.svh"

module ygb_rgb_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ygb_pkg::ctl_t     ctl_i,
  input  ygb_pkg::rgb_t     rgb_i,
  input  logic [4:0]        depth_i,
  output logic              done_o,
  output ygb_pkg::pix_out_t pix_o
);
  import ygb_pkg::*;

  localparam int KY [3] = '{1053, 2064, 401};
  localparam int KU [3] = '{606, 1192, 1798};
  localparam int KV [3] = '{1798, 1507, 291};

  function automatic logic [15:0] to_depth(input logic signed [31:0] s,
                                           input logic [4:0] d);
    logic [31:0] v;
    logic [16:0] maxv;
    v    = 32'(s) >> (5'd30 - d);
    maxv = 17'((18'd1 << d) - 18'd1);
    if (s <= 0) return '0;
    if (v > 32'(maxv)) return maxv[15:0];
    return v[15:0];
  endfunction

  logic [29:0]        py_d [3];
  logic [29:0]        pu_d [3];
  logic [29:0]        pv_d [3];
  logic [29:0]        py_q [3];
  logic [29:0]        pu_q [3];
  logic [29:0]        pv_q [3];
  logic signed [31:0] ys_d, us_d, vs_d, ys_q, us_q, vs_q;
  ctl_t               k1_ctl_q, k2_ctl_q;
  logic               done_q;
  pix_out_t           pix_d, pix_q;

  // Coefficient products.
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      py_d[ch] = 30'(rgb_i[ch]) * 30'(KY[ch]);
      pu_d[ch] = 30'(rgb_i[ch]) * 30'(KU[ch]);
      pv_d[ch] = 30'(rgb_i[ch]) * 30'(KV[ch]);
    end
  end

  // Signed sums with the studio offsets in Q.22.
  always_comb begin
    ys_d = 32'(py_q[0]) + 32'(py_q[1]) + 32'(py_q[2]) + 32'(16 << 22);
    us_d = 32'(pu_q[2]) - 32'(pu_q[0]) - 32'(pu_q[1]) + 32'(128 << 22);
    vs_d = 32'(pv_q[0]) - 32'(pv_q[1]) - 32'(pv_q[2]) + 32'(128 << 22);
  end

  // Scale to the depth; chroma only at sampling sites.
  always_comb begin
    pix_d.luma_out      = to_depth(ys_q, depth_i);
    pix_d.blue_diff_out = k2_ctl_q.site ? to_depth(us_q, depth_i) : '0;
    pix_d.red_diff_out  = k2_ctl_q.site ? to_depth(vs_q, depth_i) : '0;
    pix_d.chroma_valid  = k2_ctl_q.site;
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k1_ctl_q <= '0;
      k2_ctl_q <= '0;
      done_q   <= 1'b0;
    end else begin
      k1_ctl_q <= ctl_i;
      k2_ctl_q <= k1_ctl_q;
      done_q   <= k2_ctl_q.valid;
    end
  end

  // Data registers.
  always_ff @(posedge clk_i) begin
    for (int ch = 0; ch < 3; ch++) begin
      py_q[ch] <= py_d[ch];
      pu_q[ch] <= pu_d[ch];
      pv_q[ch] <= pv_d[ch];
    end
    ys_q  <= ys_d;
    us_q  <= us_d;
    vs_q  <= vs_d;
    pix_q <= pix_d;
  end

  assign done_o = done_q;
  assign pix_o  = pix_q;

  `YGB_ASSERT_IMPLY(a_back_chroma, clk_i, rst_ni, done_o && !pix_o.chroma_valid, (pix_o.blue_diff_out == '0) && (pix_o.red_diff_out == '0))

endmodule

`default_nettype wire
